// File: src/off_mesh_text_parser_defines.svh
// Assertion macros for the OFF mesh text parser.
// Included by the RTL files that carry assertions; no other dependencies.
`ifndef OFF_MESH_TEXT_PARSER_DEFINES_SVH
`define OFF_MESH_TEXT_PARSER_DEFINES_SVH
`ifndef SYNTHESIS
`define OMT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("off_mesh_text_parser: assertion failed");
`define OMT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("off_mesh_text_parser: assertion failed");
`else
`define OMT_ASSERT_IMP(label, clk, rst, ante, cons)
`define OMT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: src/omt_pkg.sv
// Types, character codes and status codes for the OFF mesh text parser.
// No dependencies.
package omt_pkg;
   localparam int MAX_TOKEN_CHARS = 18;
   localparam int COUNT_BITS      = 32;
   localparam int VALUE_BITS      = 60;
   localparam int CHAR_BITS       = 5;

   typedef logic [7:0]            byte_type;
   typedef logic [VALUE_BITS-1:0] value_type;
   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [CHAR_BITS-1:0]  char_count_type;
   typedef logic [2:0]            kind_type;
   typedef logic [4:0]            frac_type;
   typedef logic [1:0]            axis_type;
   typedef logic [3:0]            status_type;
   typedef logic [2:0]            phase_type;
   typedef logic [1:0]            mark_type;

   localparam byte_type CH_UPPER_O = 8'h4F;
   localparam byte_type CH_LOWER_O = 8'h6F;
   localparam byte_type CH_UPPER_F = 8'h46;
   localparam byte_type CH_LOWER_F = 8'h66;
   localparam byte_type CH_BAR     = 8'h7C;
   localparam byte_type CH_SPACE   = 8'h20;
   localparam byte_type CH_TAB     = 8'h09;
   localparam byte_type CH_NEWLINE = 8'h0A;
   localparam byte_type CH_POINT   = 8'h2E;
   localparam byte_type CH_ZERO    = 8'h30;
   localparam byte_type CH_NINE    = 8'h39;

   localparam phase_type PH_SEARCH = 3'd0;
   localparam phase_type PH_VCOUNT = 3'd1;
   localparam phase_type PH_FCOUNT = 3'd2;
   localparam phase_type PH_ECOUNT = 3'd3;
   localparam phase_type PH_COORD  = 3'd4;
   localparam phase_type PH_DEGREE = 3'd5;
   localparam phase_type PH_INDEX  = 3'd6;

   localparam mark_type MARK_NONE = 2'd0;
   localparam mark_type MARK_O    = 2'd1;
   localparam mark_type MARK_OF   = 2'd2;

   localparam kind_type KIND_NONE = 3'd6;

   localparam axis_type AXIS_X = 2'd0;
   localparam axis_type AXIS_Z = 2'd2;

   localparam status_type ST_RUNNING    = 4'd0;
   localparam status_type ST_DONE       = 4'd1;
   localparam status_type ST_NO_MARK    = 4'd2;
   localparam status_type ST_BAD_TOKEN  = 4'd3;
   localparam status_type ST_TOO_LONG   = 4'd4;
   localparam status_type ST_LOW_DEGREE = 4'd5;
   localparam status_type ST_INDEX_RANGE = 4'd6;
   localparam status_type ST_TWO_POINTS = 4'd7;
   localparam status_type ST_OVERFLOW   = 4'd8;
endpackage

// File: src/omt_req_if.sv
// Input channel of the OFF mesh text parser: one text character per item.
// Depends on omt_pkg.
interface omt_req_if;
   logic              valid;
   logic              ready;
   omt_pkg::byte_type byte_in;
   logic              end_of_text;

   modport source (output valid, byte_in, end_of_text, input ready);
   modport sink   (input valid, byte_in, end_of_text, output ready);
endinterface

// File: src/omt_rsp_if.sv
// Result channel of the OFF mesh text parser: one token or status per item.
// Depends on omt_pkg.
interface omt_rsp_if;
   logic                valid;
   logic                ready;
   omt_pkg::kind_type   token_kind;
   omt_pkg::value_type  token_value;
   omt_pkg::frac_type   fraction_digits;
   omt_pkg::axis_type   coord_axis;
   omt_pkg::status_type status;

   modport source (output valid, token_kind, token_value, fraction_digits, coord_axis,
                   status, input ready);
   modport sink   (input valid, token_kind, token_value, fraction_digits, coord_axis,
                   status, output ready);
endinterface

// File: src/off_mesh_text_parser.sv
// OFF mesh text parser: one character per item, tokens out as they finish.
// The character passes through an input register, then a result register.
// Throughput: one character per cycle, set by the combinational multiply-by-ten
// add and token checks on the parse state; a stalled result holds the input.
// Reset (synchronous, active high) empties both registers and restarts the
// mark search; end_of_text on a character restarts the search after it.
// Depends on omt_pkg, omt_req_if, omt_rsp_if and the defines header.
`include "off_mesh_text_parser_defines.svh"
module off_mesh_text_parser (
   input  logic         clock,
   input  logic         reset,
   omt_req_if.sink      req_if,
   omt_rsp_if.source    rsp_if
);
   import omt_pkg::*;

   localparam char_count_type CHAR_MAX = CHAR_BITS'(MAX_TOKEN_CHARS);

   logic           in_valid_ff, in_valid_in;
   byte_type       byte_ff;
   logic           eot_ff;
   logic           advance;

   phase_type      phase_ff, phase_in;
   mark_type       mark_ff, mark_in;
   count_type      vertex_total_ff, vertex_total_in;
   count_type      face_total_ff, face_total_in;
   count_type      items_left_ff, items_left_in;
   count_type      indices_left_ff, indices_left_in;
   axis_type       axis_ff, axis_in;
   value_type      acc_ff, acc_in;
   char_count_type char_count_ff, char_count_in;
   frac_type       frac_count_ff, frac_count_in;
   logic           point_ff, point_in;
   logic           finished_ff, finished_in;

   logic           rsp_valid_ff, rsp_valid_in;
   kind_type       kind_ff, kind_in;
   value_type      value_ff, value_in;
   frac_type       frac_ff, frac_in;
   axis_type       raxis_ff, raxis_in;
   status_type     status_ff, status_in;
   logic           have;

   logic           is_o, is_f, is_digit, is_point, is_sep, tok;
   logic           do_complete, over;
   value_type      acc_mul;
   count_type      tok_count, items_dec, indices_dec;

   assign advance      = in_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !in_valid_ff || advance;

   assign is_o     = (byte_ff == CH_UPPER_O) || (byte_ff == CH_LOWER_O);
   assign is_f     = (byte_ff == CH_UPPER_F) || (byte_ff == CH_LOWER_F);
   assign is_digit = (byte_ff >= CH_ZERO) && (byte_ff <= CH_NINE);
   assign is_point = (byte_ff == CH_POINT);
   assign is_sep   = (byte_ff == CH_SPACE) || (byte_ff == CH_TAB) ||
                     (byte_ff == CH_NEWLINE) || (byte_ff == CH_BAR);
   assign tok      = is_digit || ((phase_ff == PH_COORD) && is_point);
   assign acc_mul  = (acc_ff << 3) + (acc_ff << 1) + VALUE_BITS'(byte_ff[3:0]);
   assign items_dec   = items_left_ff - 1'b1;
   assign indices_dec = indices_left_ff - 1'b1;

   always_comb begin
      phase_in        = phase_ff;
      mark_in         = mark_ff;
      vertex_total_in = vertex_total_ff;
      face_total_in   = face_total_ff;
      items_left_in   = items_left_ff;
      indices_left_in = indices_left_ff;
      axis_in         = axis_ff;
      acc_in          = acc_ff;
      char_count_in   = char_count_ff;
      frac_count_in   = frac_count_ff;
      point_in        = point_ff;
      finished_in     = finished_ff;
      have            = 1'b0;
      kind_in         = KIND_NONE;
      value_in        = '0;
      frac_in         = '0;
      raxis_in        = AXIS_X;
      status_in       = ST_RUNNING;
      do_complete     = 1'b0;
      over            = 1'b0;
      tok_count       = '0;

      if (!finished_ff) begin
         if (phase_ff == PH_SEARCH) begin
            if (mark_ff == MARK_OF && is_f && !eot_ff) begin
               phase_in = PH_VCOUNT;
               mark_in  = MARK_NONE;
            end else if (is_o) begin
               mark_in = MARK_O;
            end else if (mark_ff == MARK_O && is_f) begin
               mark_in = MARK_OF;
            end else begin
               mark_in = MARK_NONE;
            end
            if (eot_ff && phase_in == PH_SEARCH) begin
               have        = 1'b1;
               status_in   = ST_NO_MARK;
               finished_in = 1'b1;
            end
         end else begin
            if (tok) begin
               if (char_count_ff >= CHAR_MAX) begin
                  have        = 1'b1;
                  status_in   = ST_TOO_LONG;
                  finished_in = 1'b1;
               end else if (is_point) begin
                  if (point_ff) begin
                     have        = 1'b1;
                     status_in   = ST_TWO_POINTS;
                     finished_in = 1'b1;
                  end else begin
                     point_in      = 1'b1;
                     char_count_in = char_count_ff + 1'b1;
                  end
               end else begin
                  acc_in        = acc_mul;
                  char_count_in = char_count_ff + 1'b1;
                  if (point_ff) begin
                     frac_count_in = frac_count_ff + 1'b1;
                  end
               end
               do_complete = eot_ff && !finished_in;
            end else begin
               do_complete = (char_count_ff != '0);
            end

            if (do_complete) begin
               // token kind follows phase order, vertex count first
               have      = 1'b1;
               kind_in   = 3'(phase_ff - PH_VCOUNT);
               value_in  = acc_in;
               frac_in   = (phase_ff == PH_COORD) ? frac_count_in : '0;
               raxis_in  = (phase_ff == PH_COORD) ? axis_ff : AXIS_X;
               over      = (acc_in[VALUE_BITS-1:COUNT_BITS] != '0);
               tok_count = acc_in[COUNT_BITS-1:0];
               acc_in        = '0;
               char_count_in = '0;
               frac_count_in = '0;
               point_in      = 1'b0;
               if (phase_ff != PH_COORD && over) begin
                  status_in   = ST_OVERFLOW;
                  finished_in = 1'b1;
               end else begin
                  case (phase_ff)
                     PH_VCOUNT: begin
                        vertex_total_in = tok_count;
                        phase_in        = PH_FCOUNT;
                     end
                     PH_FCOUNT: begin
                        face_total_in = tok_count;
                        phase_in      = PH_ECOUNT;
                     end
                     PH_ECOUNT: begin
                        if (vertex_total_ff == '0) begin
                           status_in   = ST_DONE;
                           finished_in = 1'b1;
                        end else begin
                           items_left_in = vertex_total_ff;
                           axis_in       = AXIS_X;
                           phase_in      = PH_COORD;
                        end
                     end
                     PH_COORD: begin
                        axis_in = axis_ff + 1'b1;
                        if (axis_ff == AXIS_Z) begin
                           axis_in       = AXIS_X;
                           items_left_in = items_dec;
                           if (items_dec == '0) begin
                              if (face_total_ff == '0) begin
                                 status_in   = ST_DONE;
                                 finished_in = 1'b1;
                              end else begin
                                 items_left_in = face_total_ff;
                                 phase_in      = PH_DEGREE;
                              end
                           end
                        end
                     end
                     PH_DEGREE: begin
                        if (tok_count < COUNT_BITS'(3)) begin
                           status_in   = ST_LOW_DEGREE;
                           finished_in = 1'b1;
                        end else begin
                           indices_left_in = tok_count;
                           phase_in        = PH_INDEX;
                        end
                     end
                     PH_INDEX: begin
                        if (tok_count >= vertex_total_ff) begin
                           status_in   = ST_INDEX_RANGE;
                           finished_in = 1'b1;
                        end else begin
                           indices_left_in = indices_dec;
                           if (indices_dec == '0) begin
                              items_left_in = items_dec;
                              if (items_dec == '0) begin
                                 status_in   = ST_DONE;
                                 finished_in = 1'b1;
                              end else begin
                                 phase_in = PH_DEGREE;
                              end
                           end
                        end
                     end
                     default: begin
                        status_in   = ST_BAD_TOKEN;
                        finished_in = 1'b1;
                     end
                  endcase
               end
            end

            if (!finished_in && ((!tok && !is_sep) || eot_ff)) begin
               have        = 1'b1;
               status_in   = ST_BAD_TOKEN;
               finished_in = 1'b1;
            end
         end
      end

      if (eot_ff) begin
         phase_in        = PH_SEARCH;
         mark_in         = MARK_NONE;
         vertex_total_in = '0;
         face_total_in   = '0;
         items_left_in   = '0;
         indices_left_in = '0;
         axis_in         = AXIS_X;
         acc_in          = '0;
         char_count_in   = '0;
         frac_count_in   = '0;
         point_in        = 1'b0;
         finished_in     = 1'b0;
      end
   end

   always_comb begin
      if (req_if.valid && req_if.ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      if (advance) begin
         rsp_valid_in = have;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         phase_ff        <= PH_SEARCH;
         mark_ff         <= MARK_NONE;
         vertex_total_ff <= '0;
         face_total_ff   <= '0;
         items_left_ff   <= '0;
         indices_left_ff <= '0;
         axis_ff         <= AXIS_X;
         acc_ff          <= '0;
         char_count_ff   <= '0;
         frac_count_ff   <= '0;
         point_ff        <= 1'b0;
         finished_ff     <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            phase_ff        <= phase_in;
            mark_ff         <= mark_in;
            vertex_total_ff <= vertex_total_in;
            face_total_ff   <= face_total_in;
            items_left_ff   <= items_left_in;
            indices_left_ff <= indices_left_in;
            axis_ff         <= axis_in;
            acc_ff          <= acc_in;
            char_count_ff   <= char_count_in;
            frac_count_ff   <= frac_count_in;
            point_ff        <= point_in;
            finished_ff     <= finished_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         byte_ff <= req_if.byte_in;
         eot_ff  <= req_if.end_of_text;
      end
      if (advance && have) begin
         kind_ff   <= kind_in;
         value_ff  <= value_in;
         frac_ff   <= frac_in;
         raxis_ff  <= raxis_in;
         status_ff <= status_in;
      end
   end

   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.token_kind      = kind_ff;
   assign rsp_if.token_value     = value_ff;
   assign rsp_if.fraction_digits = frac_ff;
   assign rsp_if.coord_axis      = raxis_ff;
   assign rsp_if.status          = status_ff;

   `OMT_ASSERT_IMP(a_status_only_ends, clock, reset, rsp_valid_ff && kind_ff == KIND_NONE, status_ff != ST_RUNNING)
   `OMT_ASSERT_IMP(a_token_length, clock, reset, 1'b1, char_count_ff <= CHAR_MAX)
   `OMT_ASSERT_IMP(a_frac_in_token, clock, reset, 1'b1, frac_count_ff <= char_count_ff)
   `OMT_ASSERT_IMP(a_search_empty, clock, reset, phase_ff == PH_SEARCH, char_count_ff == '0 && !point_ff)
   `OMT_ASSERT_NEXT(a_stall_holds_input, clock, reset, in_valid_ff && rsp_valid_ff && !rsp_if.ready, in_valid_ff)
endmodule
